>>> hdl/target_distance_heading_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for target_distance_heading
// Shared wrappers that clock on clk_i and hold off while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef TARGET_DISTANCE_HEADING_DEFINES_SVH
`define TARGET_DISTANCE_HEADING_DEFINES_SVH

// Checks that a property holds at every rising clock edge out of reset.
`define TDH_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checks that a condition is never true at a rising clock edge out of reset.
`define TDH_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

>>> hdl/tdh_pkg.sv
// ----------------------------------------------------------------------------
// tdh_pkg
// Constants, types and the arctangent table of the distance and heading block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package tdh_pkg;

  localparam int CORDIC_ITERATIONS = 16;
  localparam int ANGLE_BITS        = 16;

  localparam int POS_W   = 32;
  localparam int OFS_W   = 33;
  localparam int DIST_W  = 33;
  localparam int HEAD_W  = 16;
  localparam int CFG_W   = 32;
  localparam int CFG_IDX_W = 2;

  // Rotation datapath width; the CORDIC gain grows the length by about 1.65.
  localparam int XW      = 36;
  localparam int ITER_W  = $clog2(CORDIC_ITERATIONS);
  localparam int GAIN_W  = 16;
  localparam int FRAC_W  = 16;
  localparam int PROD_W  = XW - 1 + GAIN_W;

  localparam logic [GAIN_W-1:0] GAIN_HI      = 16'h9B74;
  localparam logic [GAIN_W-1:0] GAIN_LO      = 16'hEDA8;
  localparam logic [DIST_W-1:0] DIST_MAX     = 33'd6074001000;
  localparam logic [CFG_W-1:0]  THRESH_RESET = 32'd655;

  localparam int HEAD_SHR = (ANGLE_BITS >= HEAD_W) ? ANGLE_BITS - HEAD_W : 0;
  localparam int HEAD_SHL = (ANGLE_BITS <  HEAD_W) ? HEAD_W - ANGLE_BITS : 0;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TARGET_X         = 2'd0,
    REG_TARGET_Y         = 2'd1,
    REG_ARRIVE_THRESHOLD = 2'd2
  } reg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ROT,
    ST_MUL_LO,
    ST_MUL_HI,
    ST_SUM,
    ST_FIN
  } state_e;

  // Arctangent of 2^-i in Q32 turns.
  localparam logic [31:0] ATAN_Q32 [32] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
    32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
    32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
    32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000
  };

  // Rounds one table entry to the angle accumulator width.
  function automatic logic [ANGLE_BITS-1:0] atan_step(input logic [4:0] idx);
    logic [32:0] r;
    r = {1'b0, ATAN_Q32[idx]} + (33'd1 << (31 - ANGLE_BITS));
    return r[32-ANGLE_BITS +: ANGLE_BITS];
  endfunction

endpackage

`default_nettype wire

>>> hdl/target_distance_heading.sv
// ----------------------------------------------------------------------------
// target_distance_heading
// Forms the offset from the current position to a configured target and
// returns its length and heading through an iterative CORDIC in vectoring
// mode. All values are Q16.16; heading is in 1/65536 turns, [0, 1 turn).
// Each item steps through ST_ROT (16 iterations through a single add and
// shift unit), then ST_MUL_LO and ST_MUL_HI on the one shared 35 by 16 bit
// multiplier that removes the CORDIC gain, ST_SUM for the sum and ST_FIN to
// round, saturate and compare against the arrival threshold; ST_FIN waits
// while the previous result is held on the output. No new item is taken
// before the current one leaves ST_FIN, but a new item is taken while the
// previous result is still waiting on the output. Below the threshold the
// distance reads 0, arrived is set and the previous heading is repeated.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "target_distance_heading_defines.svh"

module target_distance_heading
  import tdh_pkg::*;
(
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,

  input  wire logic                     cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]     cfg_idx_i,
  input  wire logic [CFG_W-1:0]         cfg_data_i,

  input  wire logic                     in_valid_i,
  output logic                          in_ready_o,
  input  wire logic signed [POS_W-1:0]  pos_x_i,
  input  wire logic signed [POS_W-1:0]  pos_y_i,

  output logic                          out_valid_o,
  input  wire logic                     out_ready_i,
  output logic signed [OFS_W-1:0]       offset_x_o,
  output logic signed [OFS_W-1:0]       offset_y_o,
  output logic [DIST_W-1:0]             distance_o,
  output logic [HEAD_W-1:0]             heading_o,
  output logic                          arrived_o
);

  state_e                   state_q, state_d;
  logic [ITER_W-1:0]        iter_q, iter_d;

  logic signed [POS_W-1:0]  target_x_q, target_y_q;
  logic [CFG_W-1:0]         thresh_q;
  logic [HEAD_W-1:0]        last_heading_q;
  logic                     out_valid_q;

  logic signed [OFS_W-1:0]  dx_q, dy_q;
  logic signed [XW-1:0]     x_q, y_q;
  logic [ANGLE_BITS-1:0]    acc_q;
  logic [PROD_W-1:0]        prod_lo_q, prod_hi_q;
  logic [PROD_W:0]          sum_q;

  logic signed [OFS_W-1:0]  dx_in, dy_in, ndx_in, ndy_in;
  logic signed [XW-1:0]     xs, ys, x_rot, y_rot;
  logic [ANGLE_BITS-1:0]    step, acc_rot;
  logic [XW-2:0]            ux;
  logic [GAIN_W-1:0]        mul_b;
  logic [PROD_W-1:0]        mul_p;
  logic [PROD_W:0]          sum_d;
  logic [PROD_W-FRAC_W:0]   dist_raw;
  logic [DIST_W-1:0]        dist_sat;
  logic [HEAD_W-1:0]        head_new;
  logic                     is_arrived, zero_ofs, commit;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;

  // Offsets and their negations are formed side by side at the input transfer.
  assign dx_in  = OFS_W'(target_x_q) - OFS_W'(pos_x_i);
  assign dy_in  = OFS_W'(target_y_q) - OFS_W'(pos_y_i);
  assign ndx_in = OFS_W'(pos_x_i) - OFS_W'(target_x_q);
  assign ndy_in = OFS_W'(pos_y_i) - OFS_W'(target_y_q);

  // One CORDIC micro-rotation.
  always_comb begin
    xs   = x_q >>> iter_q;
    ys   = y_q >>> iter_q;
    step = atan_step(5'(iter_q));
    if (!y_q[XW-1]) begin
      x_rot   = x_q + ys;
      y_rot   = y_q - xs;
      acc_rot = acc_q + step;
    end else begin
      x_rot   = x_q - ys;
      y_rot   = y_q + xs;
      acc_rot = acc_q - step;
    end
  end

  // Shared gain multiplier, used for the low and then the high gain half.
  assign ux    = x_q[XW-1] ? '0 : x_q[XW-2:0];
  assign mul_b = (state_q == ST_MUL_LO) ? GAIN_LO : GAIN_HI;
  assign mul_p = {{GAIN_W{1'b0}}, ux} * {{(XW-1){1'b0}}, mul_b};

  assign sum_d = {1'b0, prod_hi_q} + (PROD_W+1)'(prod_lo_q >> FRAC_W)
               + ((PROD_W+1)'(1) << (FRAC_W - 1));

  always_comb begin
    dist_raw   = sum_q[PROD_W:FRAC_W];
    dist_sat   = (dist_raw > (PROD_W-FRAC_W+1)'(DIST_MAX)) ? DIST_MAX
                                                           : dist_raw[DIST_W-1:0];
    is_arrived = dist_sat < {1'b0, thresh_q};
    zero_ofs   = (dx_q == '0) && (dy_q == '0);
    head_new   = HEAD_W'(({{HEAD_W{1'b0}}, acc_q} << HEAD_SHL) >> HEAD_SHR);
  end

  always_comb begin
    state_d = state_q;
    iter_d  = iter_q;
    commit  = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = ST_ROT;
          iter_d  = '0;
        end
      end
      ST_ROT: begin
        iter_d = iter_q + 1'b1;
        if (iter_q == ITER_W'(CORDIC_ITERATIONS - 1)) begin
          state_d = ST_MUL_LO;
        end
      end
      ST_MUL_LO: state_d = ST_MUL_HI;
      ST_MUL_HI: state_d = ST_SUM;
      ST_SUM:    state_d = ST_FIN;
      ST_FIN: begin
        if (!out_valid_q || out_ready_i) begin
          commit  = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= ST_IDLE;
      iter_q         <= '0;
      target_x_q     <= '0;
      target_y_q     <= '0;
      thresh_q       <= THRESH_RESET;
      last_heading_q <= '0;
      out_valid_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      iter_q  <= iter_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_TARGET_X:         target_x_q <= cfg_data_i;
          REG_TARGET_Y:         target_y_q <= cfg_data_i;
          REG_ARRIVE_THRESHOLD: thresh_q   <= cfg_data_i;
          default: ;
        endcase
      end
      if (commit) begin
        out_valid_q <= 1'b1;
        if (!is_arrived && !zero_ofs) begin
          last_heading_q <= head_new;
        end
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          dx_q <= dx_in;
          dy_q <= dy_in;
          if (dx_in[OFS_W-1]) begin
            x_q   <= XW'(ndx_in);
            y_q   <= XW'(ndy_in);
            acc_q <= ANGLE_BITS'(1) << (ANGLE_BITS - 1);
          end else begin
            x_q   <= XW'(dx_in);
            y_q   <= XW'(dy_in);
            acc_q <= '0;
          end
        end
      end
      ST_ROT: begin
        x_q   <= x_rot;
        y_q   <= y_rot;
        acc_q <= acc_rot;
      end
      ST_MUL_LO: prod_lo_q <= mul_p;
      ST_MUL_HI: prod_hi_q <= mul_p;
      ST_SUM:    sum_q     <= sum_d;
      ST_FIN: begin
        if (commit) begin
          offset_x_o <= dx_q;
          offset_y_o <= dy_q;
          arrived_o  <= is_arrived;
          if (is_arrived || zero_ofs) begin
            distance_o <= '0;
            heading_o  <= last_heading_q;
          end else begin
            distance_o <= dist_sat;
            heading_o  <= head_new;
          end
        end
      end
      default: ;
    endcase
  end

  `TDH_ASSERT(a_start_rot, (in_valid_i && in_ready_o) |=> (state_q == ST_ROT && iter_q == '0),
              "Input transfer did not start the rotation sequence.")
  `TDH_ASSERT_NEVER(a_x_negative, (state_q == ST_ROT) && x_q[XW-1],
                    "CORDIC x component went negative.")
  `TDH_ASSERT(a_arrived_zero, (out_valid_o && arrived_o) |-> (distance_o == '0),
              "Arrived result carries a nonzero distance.")
  `TDH_ASSERT(a_dist_max, out_valid_o |-> (distance_o <= DIST_MAX),
              "Distance exceeds its saturation limit.")
  `TDH_ASSERT(a_result_source, $rose(out_valid_o) |-> $past(state_q == ST_FIN),
              "Result appeared without finishing an item.")

endmodule

`default_nettype wire
